[rtl/core/qbbs_pkg.sv]
// Shared types and constants for the quadrant block bitmap store.
// No dependencies; used by the interfaces, qbbs_locate and the top unit.
package qbbs_pkg;

  // Board geometry
  localparam int BLOCK_SIDE = 32;
  localparam int SHELLS = 8;
  localparam int QUADRANTS = 4;

  localparam int BLOCKS_PER_QUAD = SHELLS * SHELLS;
  localparam int STORE_DEPTH = QUADRANTS * BLOCKS_PER_QUAD * BLOCK_SIDE;

  // Widths
  localparam int COORD_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W = $clog2(STORE_DEPTH);
  localparam int COL_W = $clog2(BLOCK_SIDE);
  localparam int SHELL_W = (SHELLS > 1) ? $clog2(SHELLS) : 1;
  localparam int IDX_W = $clog2(BLOCKS_PER_QUAD) + 1;
  localparam int QUAD_W = $clog2(QUADRANTS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 1'b1;

  // Access codes
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Row location of one cell
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             beyond;
  } loc_t;

endpackage

[rtl/core/qbbs_if.sv]
// Valid/ready channel interfaces for input words and result words.
// Depends on qbbs_pkg for the coordinate width.
interface qbbs_item_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     action;
  logic signed [qbbs_pkg::COORD_W-1:0]      pos_x;
  logic signed [qbbs_pkg::COORD_W-1:0]      pos_y;
  logic                                     cell_value;

  modport source (output valid, action, pos_x, pos_y, cell_value, input ready);
  modport sink (input valid, action, pos_x, pos_y, cell_value, output ready);
endinterface

interface qbbs_result_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     cell_out;
  logic                                     beyond_capacity;
  logic signed [qbbs_pkg::COORD_W-1:0]      low_x;
  logic signed [qbbs_pkg::COORD_W-1:0]      high_x;
  logic signed [qbbs_pkg::COORD_W-1:0]      low_y;
  logic signed [qbbs_pkg::COORD_W-1:0]      high_y;

  modport source (output valid, cell_out, beyond_capacity, low_x, high_x, low_y, high_y,
                  input ready);
  modport sink (input valid, cell_out, beyond_capacity, low_x, high_x, low_y, high_y,
                output ready);
endinterface

[rtl/core/qbbs_row_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; used as the row store of the bitmap.
module qbbs_row_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/core/qbbs_locate.sv]
// Maps signed board coordinates to a row address and bit position.
// Depends on qbbs_pkg for geometry constants and loc_t.
module qbbs_locate (
  input  logic signed [qbbs_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [qbbs_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [qbbs_pkg::COORD_W-1:0] off_x_i,
  input  logic signed [qbbs_pkg::COORD_W-1:0] off_y_i,
  output qbbs_pkg::loc_t                      loc_o
);
  import qbbs_pkg::*;

  logic signed [COORD_W:0] sum_x, sum_y;
  logic [COORD_W:0]        inv_x, inv_y;
  logic [COORD_W-1:0]      fold_x, fold_y;
  logic [COORD_W-1:0]      blk_x, blk_y;
  logic [COL_W-1:0]        col_x, col_y;
  logic [SHELL_W-1:0]      sb_x, sb_y;
  logic [IDX_W-1:0]        ext_x, ext_y;
  logic [IDX_W-1:0]        idx_a, idx_b, idx_sel;
  logic [QUAD_W-1:0]       quad;
  logic                    x_lt;

  // Shift by the offsets at one extra bit, then fold negatives to -(v+1)
  assign sum_x = {pos_x_i[COORD_W-1], pos_x_i} + {off_x_i[COORD_W-1], off_x_i};
  assign sum_y = {pos_y_i[COORD_W-1], pos_y_i} + {off_y_i[COORD_W-1], off_y_i};
  assign inv_x = sum_x[COORD_W] ? ~sum_x : sum_x;
  assign inv_y = sum_y[COORD_W] ? ~sum_y : sum_y;
  assign fold_x = inv_x[COORD_W-1:0];
  assign fold_y = inv_y[COORD_W-1:0];
  assign quad = {sum_x[COORD_W], sum_y[COORD_W]};

  // Split each axis into block coordinate and in-block position
  assign blk_x = COORD_W'(fold_x / BLOCK_SIDE);
  assign blk_y = COORD_W'(fold_y / BLOCK_SIDE);
  assign col_x = COL_W'(fold_x % BLOCK_SIDE);
  assign col_y = COL_W'(fold_y % BLOCK_SIDE);

  // The shell is the larger block coordinate; beyond capacity once it reaches SHELLS
  assign x_lt = fold_x < fold_y;
  assign sb_x = blk_x[SHELL_W-1:0];
  assign sb_y = blk_y[SHELL_W-1:0];
  assign ext_x = IDX_W'(sb_x);
  assign ext_y = IDX_W'(sb_y);

  // Square-shell enumeration on narrow shell coordinates
  assign idx_a = ext_y * ext_y + ext_x;
  assign idx_b = ext_x * ext_x + ext_x + ext_x - ext_y;
  assign idx_sel = x_lt ? idx_a : idx_b;

  always_comb begin
    loc_o.beyond = x_lt ? (blk_y >= COORD_W'(SHELLS)) : (blk_x >= COORD_W'(SHELLS));
    loc_o.col = col_x;
    loc_o.row = ROW_W'((int'(quad) * BLOCKS_PER_QUAD + int'(idx_sel)) * BLOCK_SIDE
                       + int'(col_y));
  end

endmodule

[rtl/core/quadrant_block_bitmap_store_unit.sv]
// Quadrant block bitmap store: one bit per board cell at signed coordinates.
// Flow: a word reads its row in LOOKUP; in MODIFY a write updates the row, and the
// result is registered once the output is free; a new word may be accepted in MODIFY.
// Reset: offsets and bounding box clear at once; then a clearing pass writes zero to
// all STORE_DEPTH (8192) rows, one a cycle, and no word is accepted until it ends.
module quadrant_block_bitmap_store_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qbbs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qbbs_pkg::COORD_W-1:0]        cfg_wdata_i,
  qbbs_item_if.sink                           item_i,
  qbbs_result_if.source                       result_o
);
  import qbbs_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_MODIFY = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [ROW_W-1:0]          clr_cnt_q;
  logic signed [COORD_W-1:0] off_x_q, off_y_q;

  // Held word
  logic                      act_q, val_q;
  logic signed [COORD_W-1:0] px_q, py_q;

  // Location held across the RAM read
  loc_t                      loc_c, loc_q;

  // Bounding box
  logic signed [COORD_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic signed [COORD_W-1:0] lo_x_d, hi_x_d, lo_y_d, hi_y_d;

  // Result register
  logic                      out_valid_q;
  logic                      cell_q, beyond_q;
  logic signed [COORD_W-1:0] r_lo_x_q, r_hi_x_q, r_lo_y_q, r_hi_y_q;

  logic                      in_fire, out_load, out_free;
  logic                      set_bit, ram_we, ram_re;
  logic [ROW_W-1:0]          ram_waddr;
  logic [BLOCK_SIDE-1:0]     ram_wdata, ram_rdata, new_word;

  // Handshake
  assign out_free = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE) || ((state_q == ST_MODIFY) && out_free);
  assign in_fire = item_i.valid && item_i.ready;
  assign out_load = (state_q == ST_MODIFY) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == ROW_W'(STORE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) state_d = in_fire ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + ROW_W'(1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_X: off_x_q <= cfg_wdata_i;
        CFG_OFFSET_Y: off_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture an accepted word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= item_i.action;
      val_q <= item_i.cell_value;
      px_q <= item_i.pos_x;
      py_q <= item_i.pos_y;
    end
  end

  qbbs_locate u_locate (
    .pos_x_i (px_q),
    .pos_y_i (py_q),
    .off_x_i (off_x_q),
    .off_y_i (off_y_q),
    .loc_o   (loc_c)
  );

  // Hold the location for the modify cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) loc_q <= loc_c;
  end

  // Row RAM: clearing pass, or write back of the modified row
  always_comb begin
    new_word = ram_rdata;
    new_word[loc_q.col] = val_q;
  end

  assign ram_re = (state_q == ST_LOOKUP);
  assign ram_we = (state_q == ST_CLEAR) ||
                  (out_load && (act_q == ACT_WRITE) && !loc_q.beyond);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : loc_q.row;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : new_word;

  qbbs_row_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (BLOCK_SIDE)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (loc_c.row),
    .rdata_o (ram_rdata)
  );

  // Widen the box on a set within capacity
  assign set_bit = (act_q == ACT_WRITE) && val_q && !loc_q.beyond;

  always_comb begin
    lo_x_d = lo_x_q;
    hi_x_d = hi_x_q;
    lo_y_d = lo_y_q;
    hi_y_d = hi_y_q;
    if (set_bit) begin
      if (px_q < lo_x_q) lo_x_d = px_q;
      if (px_q > hi_x_q) hi_x_d = px_q;
      if (py_q < lo_y_q) lo_y_d = py_q;
      if (py_q > hi_y_q) hi_y_d = py_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_x_q <= '0;
      hi_x_q <= '0;
      lo_y_q <= '0;
      hi_y_q <= '0;
    end else if (out_load) begin
      lo_x_q <= lo_x_d;
      hi_x_q <= hi_x_d;
      lo_y_q <= lo_y_d;
      hi_y_q <= hi_y_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_q <= (act_q == ACT_READ) && !loc_q.beyond && ram_rdata[loc_q.col];
      beyond_q <= loc_q.beyond;
      r_lo_x_q <= lo_x_d;
      r_hi_x_q <= hi_x_d;
      r_lo_y_q <= lo_y_d;
      r_hi_y_q <= hi_y_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.cell_out = cell_q;
  assign result_o.beyond_capacity = beyond_q;
  assign result_o.low_x = r_lo_x_q;
  assign result_o.high_x = r_hi_x_q;
  assign result_o.low_y = r_lo_y_q;
  assign result_o.high_y = r_hi_y_q;

endmodule

[sim/quadrant_block_bitmap_store_unit_tb.sv]
// Self-checking testbench for the quadrant block bitmap store: reads and writes of board
// cells are checked against an in-bench board model across offset settings and idle patterns.
// Depends on qbbs_pkg, the qbbs_item_if/qbbs_result_if interfaces and the unit itself.
`timescale 1ns / 100ps

module quadrant_block_bitmap_store_unit_tb;
  import qbbs_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int TIMEOUT_CYCLES = 600_000;
  localparam int PHASES = 6;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_e;

  typedef struct packed {
    logic                       action;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic                       cell_value;
  } access_t;

  typedef struct packed {
    logic                       cell_out;
    logic                       beyond;
    logic signed [COORD_W-1:0]  low_x;
    logic signed [COORD_W-1:0]  high_x;
    logic signed [COORD_W-1:0]  low_y;
    logic signed [COORD_W-1:0]  high_y;
  } outcome_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [COORD_W-1:0]    cfg_wdata_i;

  qbbs_item_if   item_if ();
  qbbs_result_if result_if ();

  quadrant_block_bitmap_store_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // Board model: one row word per block row, offsets and the bounding box
  bit [BLOCK_SIDE-1:0]        board_rows [STORE_DEPTH];
  logic signed [COORD_W-1:0]  shift_x = '0;
  logic signed [COORD_W-1:0]  shift_y = '0;
  logic signed [COORD_W-1:0]  box_low_x = '0;
  logic signed [COORD_W-1:0]  box_high_x = '0;
  logic signed [COORD_W-1:0]  box_low_y = '0;
  logic signed [COORD_W-1:0]  box_high_y = '0;

  access_t    access_queue [$];
  outcome_t   predicted_outcomes [$];
  idle_kind_e idle_mode = IDLE_NONE;
  int         fail_count = 0;
  int         read_count = 0;
  int         write_count = 0;
  int         beyond_count = 0;
  int         live_reads = 0;

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Map a cell to its row and column; return 0 when the block lies beyond capacity
  function automatic bit locate_cell(input logic signed [COORD_W-1:0] px,
                                     input logic signed [COORD_W-1:0] py,
                                     output int unsigned row, output int unsigned col);
    int          sx;
    int          sy;
    int unsigned quad;
    int unsigned fx;
    int unsigned fy;
    int unsigned bx;
    int unsigned by;
    int unsigned idx;
    sx = int'(px) + int'(shift_x);
    sy = int'(py) + int'(shift_y);
    quad = 0;
    row = 0;
    col = 0;
    // Fold negative axes onto the positive quadrant
    if (sx < 0) begin
      sx = -(sx + 1);
      quad += 2;
    end
    if (sy < 0) begin
      sy = -(sy + 1);
      quad += 1;
    end
    fx = sx;
    fy = sy;
    bx = fx / BLOCK_SIDE;
    by = fy / BLOCK_SIDE;
    // Square-shell enumeration of the block pair
    if (fx < fy) idx = by * by + bx;
    else idx = bx * bx + 2 * bx - by;
    if (idx >= BLOCKS_PER_QUAD) return 1'b0;
    row = (quad * BLOCKS_PER_QUAD + idx) * BLOCK_SIDE + fy % BLOCK_SIDE;
    col = fx % BLOCK_SIDE;
    return 1'b1;
  endfunction

  // Apply one access to the board model and return the result word it should produce
  function automatic outcome_t predict_access(input access_t acc);
    outcome_t    res;
    int unsigned row;
    int unsigned col;
    bit          in_range;
    in_range = locate_cell(acc.pos_x, acc.pos_y, row, col);
    res.cell_out = 1'b0;
    if (acc.action == ACT_READ) read_count++;
    else write_count++;
    if (!in_range) beyond_count++;
    if (in_range) begin
      if (acc.action == ACT_READ) begin
        res.cell_out = board_rows[row][col];
        if (res.cell_out) live_reads++;
      end else if (acc.cell_value) begin
        board_rows[row][col] = 1'b1;
        if (acc.pos_x > box_high_x) box_high_x = acc.pos_x;
        if (acc.pos_x < box_low_x) box_low_x = acc.pos_x;
        if (acc.pos_y > box_high_y) box_high_y = acc.pos_y;
        if (acc.pos_y < box_low_y) box_low_y = acc.pos_y;
      end else begin
        board_rows[row][col] = 1'b0;
      end
    end
    res.beyond = !in_range;
    res.low_x = box_low_x;
    res.high_x = box_high_x;
    res.low_y = box_low_y;
    res.high_y = box_high_y;
    return res;
  endfunction

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 83;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 25;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 83;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 25;
    return 1'b0;
  endfunction

  function automatic access_t make_access(input logic action, input int px, input int py,
                                          input logic value);
    access_t acc;
    acc.action = action;
    acc.pos_x = px[COORD_W-1:0];
    acc.pos_y = py[COORD_W-1:0];
    acc.cell_value = value;
    return acc;
  endfunction

  // Pick a coordinate: mostly a tight window near the shifted origin so cells are revisited,
  // some across every shell, the rest anywhere on the 16-bit range
  function automatic int random_coord(input logic signed [COORD_W-1:0] shift);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return -int'(shift) + int'($urandom_range(0, 79)) - 40;
    if (pick < 80) return -int'(shift) + int'($urandom_range(0, 519)) - 260;
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic access_t random_access();
    return make_access(logic'($urandom_range(0, 1)), random_coord(shift_x),
                       random_coord(shift_y), logic'($urandom_range(0, 99) < 65));
  endfunction

  task automatic queue_access(input logic action, input int px, input int py,
                              input logic value);
    access_queue.push_back(make_access(action, px, py, value));
  endtask

  // Drive one register write for a cycle; the caller drops the write enable afterwards
  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COORD_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_OFFSET_X) shift_x = value;
    else shift_y = value;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // Input driver: predict each accepted word, then hold or advance
  always @(posedge clk_i) begin : word_driver
    access_t taken;
    access_t nxt;
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        taken = make_access(item_if.action, int'(item_if.pos_x), int'(item_if.pos_y),
                            item_if.cell_value);
        predicted_outcomes.push_back(predict_access(taken));
      end
      if (!item_if.valid || item_if.ready) begin
        if (access_queue.size() > 0 && !sender_idles()) begin
          nxt = access_queue.pop_front();
          item_if.valid <= 1'b1;
          item_if.action <= nxt.action;
          item_if.pos_x <= nxt.pos_x;
          item_if.pos_y <= nxt.pos_y;
          item_if.cell_value <= nxt.cell_value;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    outcome_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (predicted_outcomes.size() == 0) begin
          $display("%0t: result word with nothing expected, actual cell %0b beyond %0b",
                   $realtime, result_if.cell_out, result_if.beyond_capacity);
          fail_count++;
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("cell_out", want.cell_out, result_if.cell_out);
          check_field("beyond_capacity", want.beyond, result_if.beyond_capacity);
          check_field("low_x", want.low_x, result_if.low_x);
          check_field("high_x", want.high_x, result_if.high_x);
          check_field("low_y", want.low_y, result_if.low_y);
          check_field("high_y", want.high_y, result_if.high_y);
        end
      end
      result_if.ready <= !receiver_stalls();
    end
  end

  initial begin : stimulus
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OFFSET_X;
    cfg_wdata_i = '0;
    item_if.valid = 1'b0;
    item_if.action = ACT_READ;
    item_if.pos_x = '0;
    item_if.pos_y = '0;
    item_if.cell_value = 1'b0;
    result_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // Let the block drain before touching the offsets; sample once the edge has settled
      while (access_queue.size() > 0 || predicted_outcomes.size() > 0 || item_if.valid)
        @(negedge clk_i);
      if (phase > 0) begin
        @(posedge clk_i);
        case (phase)
          1: begin ox = 16'sh7fff; oy = 16'sh8000; end
          2: begin ox = 16'sh8000; oy = 16'sh7fff; end
          3: begin
            ox = COORD_W'($urandom_range(0, 65535));
            oy = COORD_W'($urandom_range(0, 65535));
          end
          4: begin ox = -16'sd5; oy = 16'sd17; end
          default: begin ox = '0; oy = '0; end
        endcase
        write_offset(CFG_OFFSET_X, ox);
        write_offset(CFG_OFFSET_Y, oy);
        cfg_we_i <= 1'b0;
      end
      idle_mode = idle_kind_e'(phase % 4);

      if (phase == 0) begin
        // Origin read, set and read back, then all four quadrants
        queue_access(ACT_READ, 0, 0, 1'b0);
        queue_access(ACT_WRITE, 0, 0, 1'b1);
        queue_access(ACT_READ, 0, 0, 1'b0);
        queue_access(ACT_WRITE, -1, -1, 1'b1);
        queue_access(ACT_WRITE, 31, 5, 1'b1);
        queue_access(ACT_WRITE, 5, 40, 1'b1);
        queue_access(ACT_WRITE, 255, 255, 1'b1);
        queue_access(ACT_WRITE, 0, -256, 1'b1);
        queue_access(ACT_WRITE, -256, -256, 1'b1);
        queue_access(ACT_WRITE, -200, 100, 1'b1);
        // Beyond capacity: dropped writes and empty reads
        queue_access(ACT_WRITE, 256, 0, 1'b1);
        queue_access(ACT_READ, 256, 0, 1'b0);
        queue_access(ACT_WRITE, 0, 256, 1'b1);
        queue_access(ACT_WRITE, 32767, -32768, 1'b1);
        queue_access(ACT_READ, -32768, 32767, 1'b1);
        queue_access(ACT_WRITE, 7, 300, 1'b0);
        // Clearing write keeps the box; read value is ignored on reads
        queue_access(ACT_WRITE, 0, 0, 1'b0);
        queue_access(ACT_READ, 0, 0, 1'b1);
        queue_access(ACT_READ, -1, -1, 1'b0);
        queue_access(ACT_READ, 255, 255, 1'b0);
        queue_access(ACT_READ, 31, 5, 1'b1);
        queue_access(ACT_READ, -256, -256, 1'b0);
      end
      repeat (phase == 0 ? 155 : 175) access_queue.push_back(random_access());
    end

    while (access_queue.size() > 0 || predicted_outcomes.size() > 0 || item_if.valid)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d reads (%0d found a live cell) and %0d writes, %0d beyond capacity,",
             read_count, live_reads, write_count, beyond_count);
    $display("over %0d offset settings with and without idling on either side.", PHASES);
    if (fail_count == 0) begin
      $display("quadrant_block_bitmap_store_unit verification clean");
    end else begin
      $display("quadrant_block_bitmap_store_unit verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d words unsent and %0d results outstanding",
             access_queue.size(), predicted_outcomes.size());
    $display("quadrant_block_bitmap_store_unit verification failed");
    $finish;
  end

endmodule
